>>> src/bmffa_pkg.sv
package bmffa_pkg;

    localparam int BLOCKS      = 4096;
    localparam int BLOCK_BYTES = 4096;
    localparam int IDX_W       = $clog2(BLOCKS);
    localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
    localparam int COUNT_W     = 13;
    localparam int NEED_W      = 33 - BLOCK_SHIFT;

    localparam logic [63:0] POOL_BYTES  = 64'(BLOCKS) * 64'(BLOCK_BYTES);
    localparam logic [31:0] HEAP_BASE_RESET = 32'h0020_0000;

    localparam logic [1:0] MAP_FREE = 2'd0;
    localparam logic [1:0] MAP_LAST = 2'd1;
    localparam logic [1:0] MAP_MORE = 2'd2;

    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_NOROOM  = 2'd1;
    localparam logic [1:0] STATUS_IGNORED = 2'd2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_MARK,
        ST_FREE
    } state_t;

endpackage

>>> src/bmffa_map_ram.sv
module bmffa_map_ram (
    input  logic                       clk,
    input  logic                       we,
    input  logic [bmffa_pkg::IDX_W-1:0] waddr,
    input  logic [1:0]                 wdata,
    input  logic [bmffa_pkg::IDX_W-1:0] raddr,
    output logic [1:0]                 rdata
);
    import bmffa_pkg::*;

    logic [1:0] mem [BLOCKS];
    logic [1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/block_map_first_fit_allocator_top.sv
// First-fit block map allocator for a pool of BLOCKS blocks of BLOCK_BYTES bytes.
// A request is taken on a clock edge with start high and busy low. command 0
// allocates size_bytes rounded up to whole blocks; command 1 frees from the block
// that holds address to the end of its run. The user writes heap_base through
// heap_base_we/heap_base_wdata only while the block is idle; it is not enforced.
// Each request gives one result: done is high for one cycle with status,
// run_address, free_total and used_total. The receiver cannot stall, so the
// result is simply shown for that cycle.
// An ignored request, or one larger than the pool, answers in the cycle after it
// is taken. An allocate scans the map one entry per cycle and then writes its run
// one entry per cycle. A free walks its run one entry per cycle and stops as soon
// as it reads a free entry, so it ends at once when its first block is already
// free. The map memory reads one entry and writes one entry per cycle.
// After reset the block is busy while it clears the map, one entry per cycle.
// heap_base resets to 0x200000 and may be written then.
module block_map_first_fit_allocator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        command,
    input  logic [31:0] size_bytes,
    input  logic [31:0] address,
    input  logic        heap_base_we,
    input  logic [31:0] heap_base_wdata,
    output logic        done,
    output logic [1:0]  status,
    output logic [31:0] run_address,
    output logic [12:0] free_total,
    output logic [12:0] used_total
);
    import bmffa_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BLOCKS - 1);

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    chk_reg, chk_next;
    logic [COUNT_W-1:0]  run_reg, run_next;
    logic [COUNT_W-1:0]  need_reg, need_next;
    logic [IDX_W-1:0]    base_reg, base_next;
    logic [IDX_W-1:0]    mark_reg, mark_next;
    logic [IDX_W-1:0]    end_reg, end_next;
    logic [COUNT_W-1:0]  used_reg, used_next;
    logic [31:0]         heap_base_reg;

    logic                done_reg;
    logic [1:0]          status_reg;
    logic [31:0]         run_address_reg;
    logic [COUNT_W-1:0]  free_total_reg;
    logic [COUNT_W-1:0]  used_total_reg;

    logic                fin;
    logic [1:0]          fin_status;
    logic [31:0]         fin_addr;

    logic                map_we;
    logic [IDX_W-1:0]    map_waddr;
    logic [1:0]          map_wdata;
    logic [IDX_W-1:0]    map_raddr;
    logic [1:0]          map_rdata;

    logic                accept;
    logic [32:0]         size_sum;
    logic [NEED_W-1:0]   need_full;
    logic [32:0]         offset;
    logic                in_pool;
    logic [IDX_W-1:0]    free_idx;
    logic [COUNT_W-1:0]  run_inc;

    bmffa_map_ram u_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    assign accept    = start && (state_reg == ST_IDLE);
    assign size_sum  = {1'b0, size_bytes} + 33'(BLOCK_BYTES - 1);
    assign need_full = size_sum[32:BLOCK_SHIFT];
    assign offset    = {1'b0, address} - {1'b0, heap_base_reg};
    assign in_pool   = !offset[32] && ({32'b0, offset[31:0]} < POOL_BYTES);
    assign free_idx  = IDX_W'(offset[31:0] >> BLOCK_SHIFT);
    assign run_inc   = run_reg + COUNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            chk_reg       <= '0;
            used_reg      <= '0;
            done_reg      <= 1'b0;
            heap_base_reg <= HEAP_BASE_RESET;
        end
        else
        begin
            state_reg <= state_next;
            chk_reg   <= chk_next;
            used_reg  <= used_next;
            done_reg  <= fin;
            if (heap_base_we)
            begin
                heap_base_reg <= heap_base_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        run_reg  <= run_next;
        need_reg <= need_next;
        base_reg <= base_next;
        mark_reg <= mark_next;
        end_reg  <= end_next;
        if (fin)
        begin
            status_reg      <= fin_status;
            run_address_reg <= fin_addr;
            used_total_reg  <= used_next;
            free_total_reg  <= COUNT_W'(BLOCKS) - used_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        chk_next   = chk_reg;
        run_next   = run_reg;
        need_next  = need_reg;
        base_next  = base_reg;
        mark_next  = mark_reg;
        end_next   = end_reg;
        used_next  = used_reg;
        fin        = 1'b0;
        fin_status = STATUS_DONE;
        fin_addr   = '0;
        map_we     = 1'b0;
        map_waddr  = chk_reg;
        map_wdata  = MAP_FREE;
        map_raddr  = chk_reg + IDX_W'(1);

        case (state_reg)
            ST_CLEAR:
            begin
                map_we    = 1'b1;
                map_waddr = chk_reg;
                map_wdata = MAP_FREE;
                chk_next  = chk_reg + IDX_W'(1);
                if (chk_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                // The read issued here is for the first entry the request looks at.
                map_raddr = (command == CMD_FREE) ? free_idx : '0;
                if (accept)
                begin
                    chk_next = map_raddr;
                    run_next = '0;
                    if (command == CMD_ALLOC)
                    begin
                        if (size_bytes == 32'd0 || size_sum[32])
                        begin
                            fin        = 1'b1;
                            fin_status = STATUS_IGNORED;
                        end
                        else if (need_full > NEED_W'(BLOCKS))
                        begin
                            fin        = 1'b1;
                            fin_status = STATUS_NOROOM;
                        end
                        else
                        begin
                            need_next  = COUNT_W'(need_full);
                            state_next = ST_SCAN;
                        end
                    end
                    else if (!in_pool)
                    begin
                        fin        = 1'b1;
                        fin_status = STATUS_IGNORED;
                    end
                    else
                    begin
                        state_next = ST_FREE;
                    end
                end
            end
            ST_SCAN:
            begin
                // The read data belongs to chk_reg; the next entry is read meanwhile.
                chk_next = chk_reg + IDX_W'(1);
                if (map_rdata == MAP_FREE)
                begin
                    run_next = run_inc;
                    if (run_inc == need_reg)
                    begin
                        base_next  = chk_reg - IDX_W'(run_reg);
                        mark_next  = chk_reg - IDX_W'(run_reg);
                        end_next   = chk_reg;
                        used_next  = used_reg + need_reg;
                        state_next = ST_MARK;
                    end
                    else if (chk_reg == LAST_IDX)
                    begin
                        fin        = 1'b1;
                        fin_status = STATUS_NOROOM;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    run_next = '0;
                    if (chk_reg == LAST_IDX)
                    begin
                        fin        = 1'b1;
                        fin_status = STATUS_NOROOM;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_MARK:
            begin
                map_we    = 1'b1;
                map_waddr = mark_reg;
                map_wdata = (mark_reg == end_reg) ? MAP_LAST : MAP_MORE;
                mark_next = mark_reg + IDX_W'(1);
                if (mark_reg == end_reg)
                begin
                    fin        = 1'b1;
                    fin_status = STATUS_DONE;
                    fin_addr   = heap_base_reg + (32'(base_reg) << BLOCK_SHIFT);
                    state_next = ST_IDLE;
                end
            end
            ST_FREE:
            begin
                chk_next = chk_reg + IDX_W'(1);
                if (map_rdata == MAP_FREE)
                begin
                    fin        = 1'b1;
                    fin_status = STATUS_DONE;
                    state_next = ST_IDLE;
                end
                else
                begin
                    map_we    = 1'b1;
                    map_waddr = chk_reg;
                    map_wdata = MAP_FREE;
                    if (used_reg != '0)
                    begin
                        used_next = used_reg - COUNT_W'(1);
                    end
                    if (map_rdata == MAP_LAST || chk_reg == LAST_IDX)
                    begin
                        fin        = 1'b1;
                        fin_status = STATUS_DONE;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign run_address = run_address_reg;
    assign free_total  = free_total_reg;
    assign used_total  = used_total_reg;

`ifndef SYNTHESIS
    a_counts_sum: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (free_total + used_total == COUNT_W'(BLOCKS)))
        else $error("free and used block counts do not add up to the pool");

    a_noroom_addr: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != STATUS_DONE |-> run_address == 32'd0)
        else $error("run address given for a request that allocated nothing");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done)
        else $error("accepted request neither answered nor in progress");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= COUNT_W'(BLOCKS))
        else $error("used block count exceeds the pool");
`endif

endmodule

>>> bench/block_map_first_fit_allocator_top_tb.sv
module block_map_first_fit_allocator_top_tb;
    import bmffa_pkg::*;

    localparam int CYCLE_LIMIT   = 8_000_000;
    localparam int PHASES        = 5;
    localparam int PHASE_ITEMS   = 22;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] run_address;
        logic [12:0] free_total;
        logic [12:0] used_total;
    } alloc_result_t;

    class alloc_scoreboard;
        logic [1:0]    block_map [BLOCKS];
        int unsigned   used_count;
        logic [31:0]   heap_base;
        alloc_result_t expected_q [$];
        int            errors;
        int            taken_count;

        function new();
            int i;
            for (i = 0; i < BLOCKS; i++)
                block_map[i] = MAP_FREE;
            used_count  = 0;
            heap_base   = HEAP_BASE_RESET;
            errors      = 0;
            taken_count = 0;
        endfunction

        function void set_base(logic [31:0] value);
            heap_base = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [1:0] predict_alloc(logic [31:0] sz, output logic [31:0] run_addr);
            logic [32:0] rounded;
            int unsigned need_blocks;
            int          run_len;
            int          base_idx;
            int          i;
            int          k;
            run_addr = '0;
            if (sz == 0)
                return STATUS_IGNORED;
            rounded = {1'b0, sz} + 33'(BLOCK_BYTES - 1);
            if (rounded[32])
                return STATUS_IGNORED;
            need_blocks = int'(rounded >> BLOCK_SHIFT);
            if (need_blocks > BLOCKS)
                return STATUS_NOROOM;
            run_len = 0;
            for (i = 0; i < BLOCKS; i++)
            begin
                if (block_map[i] != MAP_FREE)
                begin
                    // An occupied block restarts the search just past it.
                    run_len = 0;
                end
                else
                begin
                    run_len++;
                    if (run_len == need_blocks)
                    begin
                        base_idx = i + 1 - run_len;
                        for (k = base_idx; k < i; k++)
                            block_map[k] = MAP_MORE;
                        block_map[i] = MAP_LAST;
                        used_count += run_len;
                        run_addr = heap_base + 32'(base_idx * BLOCK_BYTES);
                        return STATUS_DONE;
                    end
                end
            end
            return STATUS_NOROOM;
        endfunction

        function logic [1:0] predict_free(logic [31:0] adr);
            logic [32:0] lo;
            logic [32:0] hi;
            logic [1:0]  mark;
            int          idx;
            lo = {1'b0, heap_base};
            hi = lo + 33'(POOL_BYTES);
            if ({1'b0, adr} < lo || {1'b0, adr} >= hi)
                return STATUS_IGNORED;
            idx = int'(({1'b0, adr} - lo) >> BLOCK_SHIFT);
            while (idx < BLOCKS && block_map[idx] != MAP_FREE)
            begin
                mark = block_map[idx];
                block_map[idx] = MAP_FREE;
                if (used_count > 0)
                    used_count--;
                if (mark == MAP_LAST)
                    break;
                idx++;
            end
            return STATUS_DONE;
        endfunction

        function void note_request(logic cmd, logic [31:0] sz, logic [31:0] adr);
            alloc_result_t res;
            logic [31:0]   run_addr;
            run_addr = '0;
            if (cmd == CMD_ALLOC)
                res.status = predict_alloc(sz, run_addr);
            else
                res.status = predict_free(adr);
            res.run_address = run_addr;
            res.free_total  = 13'(BLOCKS - used_count);
            res.used_total  = 13'(used_count);
            if (res.status != STATUS_IGNORED)
                taken_count++;
            expected_q.push_back(res);
        endfunction

        function void check_result(logic [1:0] st, logic [31:0] run_addr,
                                   logic [12:0] free_cnt, logic [12:0] used_cnt);
            alloc_result_t exp_res;
            if (expected_q.size() == 0)
            begin
                $display("%0t unexpected result: status %0d run_address %h free %0d used %0d",
                         $time, st, run_addr, free_cnt, used_cnt);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (st !== exp_res.status)
            begin
                $display("%0t status mismatch: expected %0d, actual %0d",
                         $time, exp_res.status, st);
                errors++;
            end
            if (run_addr !== exp_res.run_address)
            begin
                $display("%0t run_address mismatch: expected %h, actual %h",
                         $time, exp_res.run_address, run_addr);
                errors++;
            end
            if (free_cnt !== exp_res.free_total)
            begin
                $display("%0t free_total mismatch: expected %0d, actual %0d",
                         $time, exp_res.free_total, free_cnt);
                errors++;
            end
            if (used_cnt !== exp_res.used_total)
            begin
                $display("%0t used_total mismatch: expected %0d, actual %0d",
                         $time, exp_res.used_total, used_cnt);
                errors++;
            end
        endfunction

        // Finds a used block, starting at a random place; with head_only set it
        // must be the first block of a run.
        function int pick_used_block(bit head_only);
            int from_idx;
            int i;
            int idx;
            from_idx = $urandom_range(0, BLOCKS - 1);
            for (i = 0; i < BLOCKS; i++)
            begin
                idx = (from_idx + i) % BLOCKS;
                if (block_map[idx] != MAP_FREE &&
                    (!head_only || idx == 0 || block_map[idx - 1] != MAP_MORE))
                    return idx;
            end
            return -1;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        command;
    logic [31:0] size_bytes;
    logic [31:0] address;
    logic        heap_base_we;
    logic [31:0] heap_base_wdata;
    logic        done;
    logic [1:0]  status;
    logic [31:0] run_address;
    logic [12:0] free_total;
    logic [12:0] used_total;

    alloc_scoreboard sb;
    int              cycle_count;

    block_map_first_fit_allocator_top uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .command         (command),
        .size_bytes      (size_bytes),
        .address         (address),
        .heap_base_we    (heap_base_we),
        .heap_base_wdata (heap_base_wdata),
        .done            (done),
        .status          (status),
        .run_address     (run_address),
        .free_total      (free_total),
        .used_total      (used_total)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("%0t run did not finish within %0d cycles", $time, CYCLE_LIMIT);
                $display("tb: failure");
                $finish;
            end
            else
            begin
                if (done)
                    sb.check_result(status, run_address, free_total, used_total);
                if (start && !busy)
                    sb.note_request(command, size_bytes, address);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the request
    // is taken, with start still high.
    task automatic send_request(logic cmd, logic [31:0] sz, logic [31:0] adr);
        start      <= 1'b1;
        command    <= cmd;
        size_bytes <= sz;
        address    <= adr;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic idle_cycles(int n);
        start <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        while (sb.pending() != 0 || busy)
            @(negedge clk);
    endtask

    task automatic write_heap_base(logic [31:0] value);
        heap_base_we    <= 1'b1;
        heap_base_wdata <= value;
        @(negedge clk);
        heap_base_we    <= 1'b0;
        sb.set_base(value);
    endtask

    task automatic random_request();
        int          pick;
        int          blk;
        int          free_bias;
        logic        cmd;
        logic [31:0] sz;
        logic [31:0] adr;
        pick      = $urandom_range(0, 99);
        free_bias = (sb.used_count > 1024) ? 70 : 35;
        cmd       = CMD_ALLOC;
        sz        = $urandom;
        adr       = $urandom;
        if (pick < 8)
        begin
            // Raw noise over the full range of every field.
            cmd = 1'($urandom_range(0, 1));
        end
        else if ($urandom_range(0, 99) >= free_bias)
        begin
            case ($urandom_range(0, 19))
                0:       sz = $urandom_range(64 * BLOCK_BYTES, BLOCKS * BLOCK_BYTES);
                1:       sz = 32'hFFFF_F000 + 32'($urandom_range(0, BLOCK_BYTES - 1));
                default: sz = $urandom_range(1, 8 * BLOCK_BYTES);
            endcase
        end
        else
        begin
            cmd = CMD_FREE;
            blk = sb.pick_used_block($urandom_range(0, 3) != 0);
            if (blk < 0)
                blk = $urandom_range(0, BLOCKS - 1);
            adr = sb.heap_base + 32'(blk * BLOCK_BYTES)
                  + 32'($urandom_range(0, BLOCK_BYTES - 1));
        end
        send_request(cmd, sz, adr);
    endtask

    initial
    begin
        logic [31:0] pool_base;
        logic [31:0] phase_bases [PHASES];
        int          phase;
        int          burst_left;
        int          phase_start;

        rst_n           = 1'b0;
        start           = 1'b0;
        command         = CMD_ALLOC;
        size_bytes      = '0;
        address         = '0;
        heap_base_we    = 1'b0;
        heap_base_wdata = '0;
        cycle_count     = 0;
        sb              = new();

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, run with heap_base at its reset value.
        pool_base = HEAP_BASE_RESET;
        send_request(CMD_ALLOC, 32'd0, '0);
        send_request(CMD_ALLOC, 32'hFFFF_F001, '0);
        send_request(CMD_ALLOC, 32'hFFFF_F000, '0);
        send_request(CMD_ALLOC, 32'h0100_0001, '0);
        send_request(CMD_ALLOC, 32'd1, '0);
        send_request(CMD_ALLOC, 32'(BLOCK_BYTES), '0);
        send_request(CMD_ALLOC, 32'(BLOCK_BYTES + 1), '0);
        send_request(CMD_ALLOC, 32'(3 * BLOCK_BYTES), '0);
        send_request(CMD_FREE, '0, pool_base + 32'(5 * BLOCK_BYTES + 7));
        send_request(CMD_FREE, '0, pool_base + 32'(5 * BLOCK_BYTES));
        send_request(CMD_FREE, '0, pool_base + 32'(BLOCK_BYTES));
        send_request(CMD_ALLOC, 32'(2 * BLOCK_BYTES), '0);
        send_request(CMD_ALLOC, 32'd1, '0);
        idle_cycles(3);
        send_request(CMD_FREE, '0, pool_base - 32'd1);
        send_request(CMD_FREE, '0, pool_base + 32'(POOL_BYTES));
        send_request(CMD_FREE, '0, pool_base + 32'(POOL_BYTES) - 32'd1);
        send_request(CMD_FREE, '0, 32'd0);
        send_request(CMD_FREE, '0, 32'hFFFF_FFFF);
        send_request(CMD_ALLOC, 32'(POOL_BYTES), '0);
        send_request(CMD_FREE, '0, pool_base);
        send_request(CMD_FREE, '0, pool_base + 32'(BLOCK_BYTES));
        send_request(CMD_FREE, '0, pool_base + 32'(2 * BLOCK_BYTES));
        send_request(CMD_FREE, '0, pool_base + 32'(4 * BLOCK_BYTES));
        send_request(CMD_ALLOC, 32'(POOL_BYTES), '0);
        send_request(CMD_FREE, '0, pool_base);

        phase_bases[0] = 32'h0000_0000;
        phase_bases[1] = 32'hFFFF_F000;
        phase_bases[2] = $urandom;
        phase_bases[3] = 32'hFFFF_FFFF;
        phase_bases[4] = HEAP_BASE_RESET;

        for (phase = 0; phase < PHASES; phase++)
        begin
            wait_for_results();
            write_heap_base(phase_bases[phase]);
            // The first address of the pool; address zero in the first phase.
            send_request(CMD_FREE, '0, sb.heap_base);
            phase_start = sb.taken_count;
            burst_left  = $urandom_range(1, 10);
            while (sb.taken_count - phase_start < PHASE_ITEMS)
            begin
                random_request();
                burst_left--;
                if ($urandom_range(0, 24) == 0)
                    wait_for_results();
                else if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 10);
                    // The third phase puts no idle cycles between bursts.
                    if (phase != 2)
                        idle_cycles($urandom_range(1, 8));
                end
            end
        end

        wait_for_results();
        repeat (BLOCKS + 16) @(negedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> sim.f
src/bmffa_pkg.sv
src/bmffa_map_ram.sv
src/block_map_first_fit_allocator_top.sv
bench/block_map_first_fit_allocator_top_tb.sv
